@@ rtl/rwat_pkg.sv @@
// ----------------------------------------------------------------------------
// rwat_pkg
// Types, constants and lookup tables shared by the admission table core.
// ----------------------------------------------------------------------------
package rwat_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int KEY_COUNT     = 256;
   localparam int OWNER_COUNT   = 256;

   // Fixed field widths of the request and response payloads
   localparam int REQ_W   = 2;
   localparam int FKEY_W  = 8;
   localparam int KIND_W  = 2;
   localparam int FOWN_W  = 8;
   localparam int SLOT_W  = 4;

   localparam int IDX_W = (TABLE_ENTRIES > 2) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CMP_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
   localparam int KEY_W = (KEY_COUNT >= (1 << FKEY_W)) ? FKEY_W : $clog2(KEY_COUNT);
   localparam int OWN_W = (OWNER_COUNT >= (1 << FOWN_W)) ? FOWN_W : $clog2(OWNER_COUNT);

   localparam logic [REQ_W-1:0]  REQ_CHECK  = 2'd0;
   localparam logic [REQ_W-1:0]  REQ_INSERT = 2'd1;
   localparam logic [REQ_W-1:0]  REQ_REMOVE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;

   typedef struct packed {
      logic [REQ_W-1:0]  req_type;
      logic [FKEY_W-1:0] event_key;
      logic [KIND_W-1:0] access_kind;
      logic [FOWN_W-1:0] owner_tag;
      logic [SLOT_W-1:0] slot_index;
   } req_payload_type;

   typedef struct packed {
      logic              admitted;
      logic              success;
      logic [SLOT_W-1:0] slot_out;
   } rsp_payload_type;

   // Request token handed from cell to cell, with its running answer
   typedef struct packed {
      logic              valid;
      logic [REQ_W-1:0]  req_type;
      logic [KEY_W-1:0]  key;
      logic [KIND_W-1:0] kind;
      logic [OWN_W-1:0]  owner;
      logic [SLOT_W-1:0] slot;
      logic              blocked;
      logic              placed;
      logic [SLOT_W-1:0] slot_out;
   } token_type;

   typedef logic [KEY_W-1:0] key_table_type [1 << FKEY_W];
   typedef logic [OWN_W-1:0] own_table_type [1 << FOWN_W];

   function automatic key_table_type build_key_table();
      key_table_type t;
      for (int i = 0; i < (1 << FKEY_W); i++) begin
         t[i] = KEY_W'(i % KEY_COUNT);
      end
      return t;
   endfunction

   function automatic own_table_type build_own_table();
      own_table_type t;
      for (int i = 0; i < (1 << FOWN_W); i++) begin
         t[i] = OWN_W'(i % OWNER_COUNT);
      end
      return t;
   endfunction

   localparam key_table_type KEY_TABLE = build_key_table();
   localparam own_table_type OWN_TABLE = build_own_table();

endpackage

@@ rtl/rwat_req_if.sv @@
// ----------------------------------------------------------------------------
// rwat_req_if
// Request channel: valid/ready handshake with the request payload.
// ----------------------------------------------------------------------------
interface rwat_req_if;
   logic                      valid;
   logic                      ready;
   rwat_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/rwat_rsp_if.sv @@
// ----------------------------------------------------------------------------
// rwat_rsp_if
// Response channel: valid/ready handshake with the response payload.
// ----------------------------------------------------------------------------
interface rwat_rsp_if;
   logic                      valid;
   logic                      ready;
   rwat_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/rwat_cell.sv @@
// ----------------------------------------------------------------------------
// rwat_cell
// One table slot. Applies the passing request to its entry and hands the
// token with the updated running answer to the next cell.
// ----------------------------------------------------------------------------
module rwat_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [rwat_pkg::IDX_W-1:0] cell_index,
   input  logic                      hold,
   input  rwat_pkg::token_type       tok_in,
   output rwat_pkg::token_type       tok_out
);

   logic                          valid_ff, valid_in;
   logic [rwat_pkg::KEY_W-1:0]    key_ff, key_in;
   logic [rwat_pkg::KIND_W-1:0]   kind_ff, kind_in;
   logic [rwat_pkg::OWN_W-1:0]    owner_ff, owner_in;
   logic                          tok_valid_ff;
   rwat_pkg::token_type           tok_ff, tok_in_next;
   logic [rwat_pkg::CMP_W-1:0]    index_ext;
   logic                          key_hit;
   logic                          active;

   assign index_ext = rwat_pkg::CMP_W'(cell_index);
   assign key_hit   = valid_ff && (key_ff == tok_in.key);
   assign active    = tok_in.valid && !hold;

   always_comb begin
      valid_in    = valid_ff;
      key_in      = key_ff;
      kind_in     = kind_ff;
      owner_in    = owner_ff;
      tok_in_next = tok_in;
      case (tok_in.req_type)
         rwat_pkg::REQ_CHECK: begin
            // a read only clashes with a write; a write clashes with anything
            if (key_hit && ((tok_in.kind != rwat_pkg::KIND_READ) ||
                            (kind_ff != rwat_pkg::KIND_READ))) begin
               tok_in_next.blocked = 1'b1;
            end
         end
         rwat_pkg::REQ_INSERT: begin
            if (!tok_in.placed && !valid_ff) begin
               valid_in             = 1'b1;
               key_in               = tok_in.key;
               kind_in              = tok_in.kind;
               owner_in             = tok_in.owner;
               tok_in_next.placed   = 1'b1;
               tok_in_next.slot_out = index_ext[rwat_pkg::SLOT_W-1:0];
            end
         end
         rwat_pkg::REQ_REMOVE: begin
            if (rwat_pkg::CMP_W'(tok_in.slot) == index_ext) begin
               valid_in = 1'b0;
               key_in   = '0;
               kind_in  = '0;
               owner_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (active) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (active) begin
         key_ff   <= key_in;
         kind_ff  <= kind_in;
         owner_ff <= owner_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_valid_ff <= 1'b0;
      end else if (!hold) begin
         tok_valid_ff <= tok_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (active) begin
         tok_ff <= tok_in_next;
      end
   end

   always_comb begin
      tok_out       = tok_ff;
      tok_out.valid = tok_valid_ff;
   end

endmodule

@@ rtl/reader_writer_admission_table_core.sv @@
// ----------------------------------------------------------------------------
// reader_writer_admission_table_core
// Reader/writer admission table built as a chain of slot cells.
// ----------------------------------------------------------------------------
// A request walks the chain of TABLE_ENTRIES slot cells, one cell per clock
// while the chain is not held for a waiting response, and each cell checks or
// updates its own slot on the way; the response is registered from the last
// cell. One request is in the chain at a time, so a new request is taken the
// cycle after the previous one reaches the response register. The response
// register lets the next request start while a response waits. Reset frees
// every slot.
module reader_writer_admission_table_core (
   input  logic        clock,
   input  logic        reset,
   rwat_req_if.sink    req,
   rwat_rsp_if.source  rsp
);

   localparam int N = rwat_pkg::TABLE_ENTRIES;

   rwat_pkg::token_type   tok [N+1];
   rwat_pkg::token_type   tok_last;
   logic                  busy_ff, busy_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rwat_pkg::rsp_payload_type rsp_ff, rsp_in;
   logic                  accept;
   logic                  hold;
   logic [N:1]            chain_valid;

   assign req.ready = !busy_ff;
   assign accept    = req.valid && !busy_ff;
   assign tok_last  = tok[N];
   assign hold      = tok_last.valid && rsp_valid_ff && !rsp.ready;

   always_comb begin
      tok[0].valid    = accept;
      tok[0].req_type = req.payload.req_type;
      tok[0].key      = rwat_pkg::KEY_TABLE[req.payload.event_key];
      tok[0].kind     = req.payload.access_kind;
      tok[0].owner    = rwat_pkg::OWN_TABLE[req.payload.owner_tag];
      tok[0].slot     = req.payload.slot_index;
      tok[0].blocked  = 1'b0;
      tok[0].placed   = 1'b0;
      tok[0].slot_out = '0;
   end

   for (genvar k = 0; k < N; k++) begin : g_cell
      rwat_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (rwat_pkg::IDX_W'(k)),
         .hold       (hold),
         .tok_in     (tok[k]),
         .tok_out    (tok[k+1])
      );
      assign chain_valid[k+1] = tok[k+1].valid;
   end

   always_comb begin
      rsp_in = rsp_ff;
      rsp_in.admitted = (tok_last.req_type == rwat_pkg::REQ_CHECK) && !tok_last.blocked;
      rsp_in.success  = ((tok_last.req_type == rwat_pkg::REQ_INSERT) && tok_last.placed) ||
                        (tok_last.req_type == rwat_pkg::REQ_REMOVE);
      rsp_in.slot_out = (tok_last.req_type == rwat_pkg::REQ_INSERT) ? tok_last.slot_out : '0;
   end

   always_comb begin
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (tok_last.valid && !hold) begin
         rsp_valid_in = 1'b1;
         busy_in      = 1'b0;
      end
      if (accept) begin
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tok_last.valid && !hold) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   // at most one request walks the chain
   a_single_token: assert property (@(posedge clock) disable iff (reset)
      $countones(chain_valid) <= 1)
      else $error("more than one request in the cell chain");

   a_busy_on_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff)
      else $error("busy not set after request accepted");

   a_token_needs_busy: assert property (@(posedge clock) disable iff (reset)
      (chain_valid != '0) |-> busy_ff)
      else $error("request in chain while not busy");

   a_slot_needs_success: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (rsp.payload.slot_out != '0) |-> rsp.payload.success)
      else $error("slot reported without success");

   a_admit_excl: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !(rsp.payload.admitted && rsp.payload.success))
      else $error("admitted and success both set");

endmodule

@@ dv/tb_reader_writer_admission_table_core.sv @@
// ----------------------------------------------------------------------------
// tb_reader_writer_admission_table_core
// Self-checking bench for the reader/writer admission table core.
// ----------------------------------------------------------------------------
// Requests go in over the request channel. A scoreboard keeps its own copy of
// the slot table, works out the answer to each accepted request and compares
// it with every accepted response in order. A directed run covers the empty,
// shared-read, conflicting-write, full-table and unused-request cases. A
// random run follows, with keys from a small pool so that conflicts are
// common, under three patterns of idling on the two channels.
// ----------------------------------------------------------------------------
module tb_reader_writer_admission_table_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [rwat_pkg::REQ_W-1:0]  REQ_UNUSED  = 2'd3;
   localparam logic [rwat_pkg::KIND_W-1:0] KIND_BOOK   = 2'd1;
   localparam logic [rwat_pkg::KIND_W-1:0] KIND_CANCEL = 2'd2;
   localparam logic [rwat_pkg::KIND_W-1:0] KIND_OTHER  = 2'd3;

   localparam int ENTRIES         = rwat_pkg::TABLE_ENTRIES;
   localparam int RANDOM_REQUESTS = 1100;
   localparam int STALL_LIMIT     = 5000;
   localparam int DRAIN_CYCLES    = ENTRIES + 4;

   class admission_scoreboard;
      logic                        slot_busy  [ENTRIES];
      logic [rwat_pkg::KEY_W-1:0]  slot_key   [ENTRIES];
      logic [rwat_pkg::KIND_W-1:0] slot_kind  [ENTRIES];
      logic [rwat_pkg::OWN_W-1:0]  slot_owner [ENTRIES];
      rwat_pkg::rsp_payload_type   expected_answers [$];
      int                          mismatches;

      function new();
         mismatches = 0;
         for (int i = 0; i < ENTRIES; i++) begin
            slot_busy[i]  = 1'b0;
            slot_key[i]   = '0;
            slot_kind[i]  = '0;
            slot_owner[i] = '0;
         end
      endfunction

      function int occupancy();
         int n;
         n = 0;
         for (int i = 0; i < ENTRIES; i++) n += int'(slot_busy[i]);
         return n;
      endfunction

      // Applies the request to the local table and returns the answer.
      function rwat_pkg::rsp_payload_type predict_answer(rwat_pkg::req_payload_type p);
         rwat_pkg::rsp_payload_type  r;
         logic [rwat_pkg::KEY_W-1:0] key;
         logic [rwat_pkg::OWN_W-1:0] owner;
         bit                         placed;
         r      = '0;
         key    = rwat_pkg::KEY_W'(p.event_key % rwat_pkg::KEY_COUNT);
         owner  = rwat_pkg::OWN_W'(p.owner_tag % rwat_pkg::OWNER_COUNT);
         placed = 1'b0;
         case (p.req_type)
            rwat_pkg::REQ_CHECK: begin
               r.admitted = 1'b1;
               for (int i = 0; i < ENTRIES; i++) begin
                  // any nonzero kind counts as a write
                  if (slot_busy[i] && slot_key[i] == key &&
                      (p.access_kind != rwat_pkg::KIND_READ ||
                       slot_kind[i] != rwat_pkg::KIND_READ))
                     r.admitted = 1'b0;
               end
            end
            rwat_pkg::REQ_INSERT: begin
               for (int i = 0; i < ENTRIES; i++) begin
                  if (!placed && !slot_busy[i]) begin
                     placed        = 1'b1;
                     slot_busy[i]  = 1'b1;
                     slot_key[i]   = key;
                     slot_kind[i]  = p.access_kind;
                     slot_owner[i] = owner;
                     r.success     = 1'b1;
                     r.slot_out    = rwat_pkg::SLOT_W'(i);
                  end
               end
            end
            rwat_pkg::REQ_REMOVE: begin
               if (int'(p.slot_index) < ENTRIES) begin
                  slot_busy[p.slot_index]  = 1'b0;
                  slot_key[p.slot_index]   = '0;
                  slot_kind[p.slot_index]  = '0;
                  slot_owner[p.slot_index] = '0;
               end
               r.success = 1'b1;
            end
            default: ;
         endcase
         return r;
      endfunction

      function void note_request(rwat_pkg::req_payload_type p);
         expected_answers.push_back(predict_answer(p));
      endfunction

      function void check_response(rwat_pkg::rsp_payload_type got);
         rwat_pkg::rsp_payload_type want;
         if (expected_answers.size() == 0) begin
            $error("response with no request outstanding: %p", got);
            mismatches++;
            return;
         end
         want = expected_answers.pop_front();
         if (got.admitted !== want.admitted) begin
            $error("admitted: expected %0d, actual %0d", want.admitted, got.admitted);
            mismatches++;
         end
         if (got.success !== want.success) begin
            $error("success: expected %0d, actual %0d", want.success, got.success);
            mismatches++;
         end
         if (got.slot_out !== want.slot_out) begin
            $error("slot_out: expected %0d, actual %0d", want.slot_out, got.slot_out);
            mismatches++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   rwat_req_if req_ch ();
   rwat_rsp_if rsp_ch ();

   reader_writer_admission_table_core dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   admission_scoreboard sb = new();

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic rwat_pkg::req_payload_type lock_request(
         logic [rwat_pkg::REQ_W-1:0]  req,
         logic [rwat_pkg::FKEY_W-1:0] key,
         logic [rwat_pkg::KIND_W-1:0] kind,
         logic [rwat_pkg::FOWN_W-1:0] owner,
         logic [rwat_pkg::SLOT_W-1:0] slot);
      rwat_pkg::req_payload_type p;
      p.req_type    = req;
      p.event_key   = key;
      p.access_kind = kind;
      p.owner_tag   = owner;
      p.slot_index  = slot;
      return p;
   endfunction

   function automatic rwat_pkg::req_payload_type random_request();
      rwat_pkg::req_payload_type p;
      int unsigned               pick;
      int unsigned               ins_pct;
      int unsigned               rem_pct;
      int unsigned               start;
      int                        used;
      // small key pool so that checks hit live entries
      p.event_key   = ($urandom_range(3) == 0) ? rwat_pkg::FKEY_W'($urandom)
                                               : rwat_pkg::FKEY_W'($urandom_range(5) | 8'hF8);
      if ($urandom_range(1) == 0) p.event_key = rwat_pkg::FKEY_W'($urandom_range(5));
      p.access_kind = ($urandom_range(9) == 0) ? KIND_OTHER
                                               : rwat_pkg::KIND_W'($urandom_range(2));
      p.owner_tag   = rwat_pkg::FOWN_W'($urandom);
      p.slot_index  = rwat_pkg::SLOT_W'($urandom);
      used    = sb.occupancy();
      ins_pct = (used < ENTRIES / 2) ? 40 : 22;
      rem_pct = (used < ENTRIES / 2) ? 15 : 33;
      pick    = $urandom_range(99);
      if (pick < 3)
         p.req_type = REQ_UNUSED;
      else if (pick < 3 + ins_pct)
         p.req_type = rwat_pkg::REQ_INSERT;
      else if (pick < 3 + ins_pct + rem_pct) begin
         p.req_type = rwat_pkg::REQ_REMOVE;
         if (used > 0 && $urandom_range(4) != 0) begin
            start = $urandom_range(ENTRIES - 1);
            for (int i = 0; i < ENTRIES; i++) begin
               if (sb.slot_busy[(start + i) % ENTRIES]) begin
                  p.slot_index = rwat_pkg::SLOT_W'((start + i) % ENTRIES);
                  break;
               end
            end
         end
      end else
         p.req_type = rwat_pkg::REQ_CHECK;
      return p;
   endfunction

   task automatic send_request(rwat_pkg::req_payload_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= p;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(p);
   endtask

   task automatic wait_for_answers();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_answers.size() != 0) @(posedge clock);
   endtask

   // response side: random back-pressure, check on every handshake
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) sb.check_response(rsp_ch.payload);
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      int stalled;
      stalled = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stalled = 0;
         else
            stalled++;
         if (stalled >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      send_idle_pct = 28;
      recv_idle_pct = 84;
      reset          = 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table admits everything
      send_request(lock_request(rwat_pkg::REQ_CHECK, 8'h00, rwat_pkg::KIND_READ, 8'h00, 4'h0));
      send_request(lock_request(rwat_pkg::REQ_CHECK, 8'hFF, KIND_OTHER, 8'hFF, 4'hF));
      send_request(lock_request(REQ_UNUSED, 8'hFF, KIND_OTHER, 8'hFF, 4'hF));
      // a read entry and a kind-three entry
      send_request(lock_request(rwat_pkg::REQ_INSERT, 8'h00, rwat_pkg::KIND_READ, 8'hFF, 4'h0));
      send_request(lock_request(rwat_pkg::REQ_INSERT, 8'hFF, KIND_OTHER, 8'h00, 4'hF));
      send_request(lock_request(rwat_pkg::REQ_CHECK, 8'h00, rwat_pkg::KIND_READ, 8'h11, 4'h0));
      send_request(lock_request(rwat_pkg::REQ_CHECK, 8'h00, KIND_BOOK, 8'h11, 4'h0));
      send_request(lock_request(rwat_pkg::REQ_CHECK, 8'hFF, rwat_pkg::KIND_READ, 8'h11, 4'h0));
      send_request(lock_request(rwat_pkg::REQ_CHECK, 8'h7F, KIND_CANCEL, 8'h11, 4'h0));
      // remove of a free slot
      send_request(lock_request(rwat_pkg::REQ_REMOVE, 8'h00, rwat_pkg::KIND_READ, 8'h00, 4'hF));
      for (int i = 2; i < ENTRIES; i++)
         send_request(lock_request(rwat_pkg::REQ_INSERT, rwat_pkg::FKEY_W'(8'h80 + i),
                                   KIND_CANCEL, rwat_pkg::FOWN_W'(i), 4'h0));
      // table full now
      send_request(lock_request(rwat_pkg::REQ_INSERT, 8'h55, KIND_BOOK, 8'hAA, 4'h0));
      send_request(lock_request(rwat_pkg::REQ_REMOVE, 8'hFF, KIND_OTHER, 8'hFF, 4'h0));
      send_request(lock_request(rwat_pkg::REQ_CHECK, 8'h00, KIND_BOOK, 8'h00, 4'h0));

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n == RANDOM_REQUESTS / 3) begin
            // hold off until the table has answered everything
            wait_for_answers();
            send_idle_pct = 84;
            recv_idle_pct = 28;
         end else if (n == 2 * RANDOM_REQUESTS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         send_request(random_request());
      end

      wait_for_answers();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_answers.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
